// File: sv/kef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kef_pkg
// Shared types and codes for the keypad event queue: item layouts, key and
// event codes, register indexes.
// ----------------------------------------------------------------------------
package kef_pkg;

    // input item as seen on the s_ channel
    typedef struct packed {
        logic cmd;
        logic ok_level_n;
        logic cancel_level_n;
        logic up_level_n;
        logic down_level_n;
    } in_item_t;

    // result item as seen on the m_ channel
    typedef struct packed {
        logic       msg_valid;
        logic [1:0] msg_type;
        logic [1:0] msg_key;
        logic       event_dropped;
        logic       queue_empty;
        logic       queue_full;
    } out_item_t;

    // key codes, zero means no key down
    typedef logic [2:0] key_code_t;
    localparam key_code_t KEY_NONE = 3'd0;
    localparam key_code_t KEY_OK   = 3'd1;
    localparam key_code_t KEY_CNCL = 3'd2;
    localparam key_code_t KEY_UP   = 3'd3;
    localparam key_code_t KEY_DN   = 3'd4;

    // input command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // event kinds stored in the queue
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_HOLD    = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 8'd1;

    // classified item passed from the front to the engine
    typedef struct packed {
        logic      is_pop;
        key_code_t key;
    } kef_cmd_t;

    // key code to the two-bit key field of a message
    function automatic logic [1:0] key_field(input key_code_t k);
        key_code_t t;
        t = k - 3'd1;
        return t[1:0];
    endfunction

endpackage

// File: sv/kef_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kef_front
// Input side: takes items from the s_ channel, resolves the key levels to a
// single key by priority and hands the classified item to the command queue.
// ----------------------------------------------------------------------------
module kef_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  kef_pkg::in_item_t  s_item,
    input  logic               q_ready,
    output logic               q_push,
    output kef_pkg::kef_cmd_t  q_data
);
    import kef_pkg::*;

    key_code_t cur_key;

    // first pressed key wins: ok, cancel, up, down
    always_comb begin
        if (!s_item.ok_level_n) begin
            cur_key = KEY_OK;
        end else if (!s_item.cancel_level_n) begin
            cur_key = KEY_CNCL;
        end else if (!s_item.up_level_n) begin
            cur_key = KEY_UP;
        end else if (!s_item.down_level_n) begin
            cur_key = KEY_DN;
        end else begin
            cur_key = KEY_NONE;
        end
    end

    // handshake into the queue
    assign s_ready       = q_ready;
    assign q_push        = s_valid & q_ready;
    assign q_data.is_pop = (s_item.cmd == CMD_POP);
    assign q_data.key    = cur_key;

endmodule

// File: sv/kef_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kef_cmd_queue
// Two-entry queue of classified items between the front and the event engine
// so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module kef_cmd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  kef_pkg::kef_cmd_t  push_data,
    output logic               push_ready,
    input  logic               pop,
    output logic               head_valid,
    output kef_pkg::kef_cmd_t  head
);
    import kef_pkg::*;

    kef_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/kef_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kef_engine
// Event engine: tracks the remembered key and the hold and repeat counters,
// pushes press, hold and release messages into the ring queue, serves pops
// and holds the result item in an output register.
// ----------------------------------------------------------------------------
module kef_engine #(
    parameter int unsigned FIFO_DEPTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    input  kef_pkg::kef_cmd_t                   head,
    output logic                                head_pop,
    input  logic [kef_pkg::CFG_DATA_W-1:0]      hold_delay,
    input  logic [kef_pkg::CFG_DATA_W-1:0]      repeat_interval,
    output logic                                m_valid,
    input  logic                                m_ready,
    output kef_pkg::out_item_t                  m_item
);
    import kef_pkg::*;

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // ring queue storage
    logic [3:0] mem [FIFO_DEPTH];

    key_code_t              last_key_reg, last_key_next;
    logic [CFG_DATA_W-1:0]  hold_count_reg, hold_count_next;
    logic [CFG_DATA_W-1:0]  repeat_count_reg, repeat_count_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;

    logic       m_valid_reg, m_valid_next;
    logic       msg_valid_reg;
    logic [3:0] rd_data_reg;
    logic       dropped_reg;
    logic       empty_reg;
    logic       full_reg;

    logic       fire;
    logic       q_empty, q_full;
    logic       ev_req;
    logic [1:0] ev_type, ev_key;
    logic       push_en, pop_en, dropped;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // take one item when the output register is free or being drained
    assign fire     = head_valid & (~m_valid_reg | m_ready);
    assign head_pop = fire;
    assign q_empty  = (rd_ptr_reg == wr_ptr_reg);
    assign q_full   = (ring_next(wr_ptr_reg) == rd_ptr_reg);

    // key tracking, hold timing and queue pointers
    always_comb begin
        last_key_next     = last_key_reg;
        hold_count_next   = hold_count_reg;
        repeat_count_next = repeat_count_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        ev_req            = 1'b0;
        ev_type           = EV_PRESS;
        ev_key            = 2'd0;
        pop_en            = 1'b0;
        if (fire) begin
            if (head.is_pop) begin
                if (!q_empty) begin
                    pop_en      = 1'b1;
                    rd_ptr_next = ring_next(rd_ptr_reg);
                end
            end else if (last_key_reg == head.key) begin
                if (head.key != KEY_NONE) begin
                    if (hold_count_reg < hold_delay) begin
                        hold_count_next   = hold_count_reg + 16'd1;
                        repeat_count_next = repeat_interval;
                    end else if (repeat_count_reg < repeat_interval) begin
                        repeat_count_next = repeat_count_reg + 16'd1;
                    end else begin
                        repeat_count_next = '0;
                        ev_req            = 1'b1;
                        ev_type           = EV_HOLD;
                        ev_key            = key_field(head.key);
                    end
                end
            end else begin
                hold_count_next = '0;
                // key to another key: no event, remembered key kept
                if (last_key_reg == KEY_NONE) begin
                    ev_req        = 1'b1;
                    ev_type       = EV_PRESS;
                    ev_key        = key_field(head.key);
                    last_key_next = head.key;
                end else if (head.key == KEY_NONE) begin
                    ev_req        = 1'b1;
                    ev_type       = EV_RELEASE;
                    ev_key        = key_field(last_key_reg);
                    last_key_next = KEY_NONE;
                end
            end
        end
        push_en = ev_req & ~q_full;
        dropped = ev_req & q_full;
        if (push_en) begin
            wr_ptr_next = ring_next(wr_ptr_reg);
        end
    end

    // output valid follows the handshake
    always_comb begin
        m_valid_next = fire | (m_valid_reg & ~m_ready);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_key_reg     <= KEY_NONE;
            hold_count_reg   <= '0;
            repeat_count_reg <= '0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            last_key_reg     <= last_key_next;
            hold_count_reg   <= hold_count_next;
            repeat_count_reg <= repeat_count_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // queue memory with registered read port
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[wr_ptr_reg] <= {ev_type, ev_key};
        end
        if (pop_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            msg_valid_reg <= pop_en;
            dropped_reg   <= dropped;
            empty_reg     <= (rd_ptr_next == wr_ptr_next);
            full_reg      <= (ring_next(wr_ptr_next) == rd_ptr_next);
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_item.msg_valid     = msg_valid_reg;
    assign m_item.msg_type      = msg_valid_reg ? rd_data_reg[3:2] : 2'd0;
    assign m_item.msg_key       = msg_valid_reg ? rd_data_reg[1:0] : 2'd0;
    assign m_item.event_dropped = dropped_reg;
    assign m_item.queue_empty   = empty_reg;
    assign m_item.queue_full    = full_reg;

endmodule

// File: sv/key_event_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_fifo_core
// Keypad press, hold and release event queue with configuration registers.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, scan tick or pop, while the output is not
// stalled and the command queue has room, and returns one result item for
// each, in order. The accepting edge writes the item into the command
// queue; the event engine then moves it into the output register. The rate
// is set by the event engine, which does the key tracking, hold counting
// and ring-queue access of an item together, at the edge that loads the
// output register. The ring queue holds FIFO_DEPTH-1 messages in a
// memory with a registered read port; it needs no clearing pass after reset.
// Configuration writes are always taken: index 0 is hold_delay, index 1 is
// repeat_interval, other indexes are ignored.
module key_event_fifo_core #(
    parameter int unsigned FIFO_DEPTH = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  kef_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output kef_pkg::out_item_t                m_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kef_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kef_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kef_pkg::*;

    logic [CFG_DATA_W-1:0] hold_delay_reg, hold_delay_next;
    logic [CFG_DATA_W-1:0] repeat_interval_reg, repeat_interval_next;

    logic     q_ready, q_push, head_valid, head_pop;
    kef_cmd_t q_data, head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        hold_delay_next      = hold_delay_reg;
        repeat_interval_next = repeat_interval_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_HOLD_DELAY:      hold_delay_next      = cfg_data;
                REG_REPEAT_INTERVAL: repeat_interval_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_delay_reg      <= 16'd50;
            repeat_interval_reg <= 16'd10;
        end else begin
            hold_delay_reg      <= hold_delay_next;
            repeat_interval_reg <= repeat_interval_next;
        end
    end

    // input classification
    kef_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    // decoupling queue
    kef_cmd_queue u_cmd_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .push_ready (q_ready),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // event engine and result register
    kef_engine #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head            (head),
        .head_pop        (head_pop),
        .hold_delay      (hold_delay_reg),
        .repeat_interval (repeat_interval_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item)
    );

endmodule

// File: sv/kef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kef_checker
// Port-level checks for the keypad event queue, bound to the top level.
// ----------------------------------------------------------------------------
module kef_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               m_valid,
    input  logic               m_ready,
    input  kef_pkg::out_item_t m_item
);
    import kef_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item withdrawn while stalled");

    // queue cannot be both empty and full
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.queue_empty && m_item.queue_full))
        else $error("queue reported empty and full");

    // a delivered message never comes with a drop or a full queue
    a_pop_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.msg_valid |-> !m_item.event_dropped && !m_item.queue_full)
        else $error("pop item reports a drop or a full queue");

    // without a message the message fields are zero
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.msg_valid |-> m_item.msg_type == 2'd0 && m_item.msg_key == 2'd0)
        else $error("message fields set without a message");

    // a drop only happens against a full queue
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.event_dropped |-> m_item.queue_full && !m_item.queue_empty)
        else $error("drop reported with room in the queue");

endmodule

bind key_event_fifo_core kef_checker u_kef_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
